### rtl/fixed_slot_pool_allocator_unit_assert.svh
// Assertion macros for the slot pool allocator.
// All macros sample on i_clk; the first two are off while i_rst_n is low.
`ifndef FIXED_SLOT_POOL_ALLOCATOR_UNIT_ASSERT_SVH
`define FIXED_SLOT_POOL_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication.
`define FSPA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define FSPA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Property checked in the cycle after reset is seen.
`define FSPA_ASSERT_RST(lbl, cons, msg) \
    lbl: assert property (@(posedge i_clk) !i_rst_n |=> (cons)) else $error(msg);

`endif

### rtl/fspa_pkg.sv
package fspa_pkg;

    // Sizes
    localparam int MAX_SLOTS   = 256;
    localparam int ADDR_BITS   = 32;
    localparam int SLOT_IDX_W  = $clog2(MAX_SLOTS);
    localparam int CNT_W       = $clog2(MAX_SLOTS + 1);
    localparam int STRIDE_W    = 17;
    localparam int ALIGN_W     = 4;
    localparam int OBJ_W       = 16;
    localparam int MAX_ALIGN   = 12;
    localparam int PAD_W       = MAX_ALIGN;
    localparam int DIVD_W      = ADDR_BITS + 1;
    localparam int DIV_CNT_W   = $clog2(DIVD_W + 1);
    localparam int SPAN_W      = CNT_W + STRIDE_W;
    localparam int MIN_OBJ     = 8;
    localparam int CFG_DATA_W  = 32;

    // Allocation scan works on groups of free-map bits
    localparam int CHUNK_W     = 8;
    localparam int CHUNK_SEL_W = $clog2(CHUNK_W);
    localparam int NUM_CHUNKS  = MAX_SLOTS / CHUNK_W;
    localparam int CHUNK_IDX_W = $clog2(NUM_CHUNKS);

    // Stream widths
    localparam int STATUS_W    = 2;
    localparam int IN_TDATA_W  = ((ADDR_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((ADDR_BITS + STATUS_W + 7) / 8) * 8;

    typedef enum logic [1:0] {
        CFG_POOL_START  = 2'd0,
        CFG_POOL_BYTES  = 2'd1,
        CFG_OBJECT_BYTES = 2'd2,
        CFG_ALIGN_LOG2  = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 2'd0,
        ST_EMPTY       = 2'd1,
        ST_BAD_ADDR    = 2'd2,
        ST_DOUBLE_FREE = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_CFG_BASE,
        S_CFG_ROOM,
        S_CFG_DIV_START,
        S_CFG_DIV_WAIT,
        S_CFG_SPAN,
        S_IDLE,
        S_ALLOC_SCAN,
        S_ALLOC_MUL,
        S_ALLOC_ADD,
        S_FREE_CHK,
        S_FREE_DIV,
        S_FREE_UPD,
        S_RESULT
    } t_state;

    // Divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

### rtl/fspa_div.sv
module fspa_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [fspa_pkg::DIVD_W-1:0]   i_dividend,
    input  logic [fspa_pkg::STRIDE_W-1:0] i_divisor,
    output fspa_pkg::t_div_stat           o_stat,
    output logic [fspa_pkg::DIVD_W-1:0]   o_quotient,
    output logic [fspa_pkg::STRIDE_W-1:0] o_remainder
);
    import fspa_pkg::*;

    logic [DIVD_W-1:0]    r_quo;
    logic [STRIDE_W-1:0]  r_rem;
    logic [STRIDE_W-1:0]  r_div;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [STRIDE_W:0]    rem_sh;
    logic                 ge;
    logic [STRIDE_W:0]    rem_sub;

    // One restoring step: shift in next dividend bit, trial subtract
    always_comb begin
        rem_sh  = {r_rem, r_quo[DIVD_W-1]};
        ge      = (rem_sh >= {1'b0, r_div});
        rem_sub = rem_sh - {1'b0, r_div};
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= DIV_CNT_W'(DIVD_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == DIV_CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIVD_W-2:0], ge};
            r_rem <= ge ? rem_sub[STRIDE_W-1:0] : rem_sh[STRIDE_W-1:0];
        end
    end

    assign o_stat.busy  = r_busy;
    assign o_stat.done  = r_done;
    assign o_quotient   = r_quo;
    assign o_remainder  = r_rem;

endmodule

### rtl/fixed_slot_pool_allocator_unit.sv
// Channel    | Dir | Handshake               | Payload
// -----------+-----+-------------------------+----------------------------------------
// request    | in  | i_s_tvalid / o_s_tready | tdata: free_address; tuser: opcode
// result     | out | o_m_tvalid / i_m_tready | tdata: slot_address, status
// config     | in  | i_cfg_we                | i_cfg_addr selects register, i_cfg_data
//
// Allocate: accept, scan (one 8-slot free-map word per cycle), multiply, add and result.
// Free: accept, range check, 33 restoring steps on the shared divider and done, map update
// and result; an address out of range goes from the range check straight to the result.
// A config write or reset rederives the layout and clears the free map one word per cycle
// during the divider wait; the request side is not ready meanwhile.
// A new request is taken while a result waits; its result is held until the output frees.
module fixed_slot_pool_allocator_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // request stream
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [fspa_pkg::IN_TDATA_W-1:0]  i_s_tdata,   // [31:0] free_address
    input  logic                             i_s_tuser,   // [0] opcode
    // result stream
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [fspa_pkg::OUT_TDATA_W-1:0] o_m_tdata,   // [31:0] slot_address, [33:32] status
    // config write port
    input  logic                             i_cfg_we,
    input  logic [1:0]                       i_cfg_addr,
    input  logic [fspa_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import fspa_pkg::*;

    t_state r_state, n_state;

    // Configuration
    logic [ADDR_BITS-1:0] r_pool_start;
    logic [ADDR_BITS-1:0] r_pool_bytes;
    logic [OBJ_W-1:0]     r_object_bytes;
    logic [ALIGN_W-1:0]   r_align_log2;

    // Derived layout
    logic [DIVD_W-1:0]    r_base_ext;
    logic [ADDR_BITS-1:0] r_aligned_base;
    logic [STRIDE_W-1:0]  r_stride;
    logic [ADDR_BITS-1:0] r_avail;
    logic [DIVD_W-1:0]    r_room;
    logic [CNT_W-1:0]     r_slot_total;
    logic [SPAN_W-1:0]    r_span;

    // Free map: one word per group of slots, bit set when the slot is free
    logic [CHUNK_W-1:0]     r_free_map [NUM_CHUNKS];
    logic [CHUNK_W-1:0]     r_map_rd;
    logic [CHUNK_IDX_W-1:0] map_raddr;

    // Current request
    logic [ADDR_BITS-1:0] r_addr;
    logic [CHUNK_IDX_W-1:0] r_chunk;
    logic [SLOT_IDX_W-1:0] r_idx;
    logic [SPAN_W-1:0]    r_prod;
    logic [ADDR_BITS-1:0] r_res_addr;
    t_status              r_res_status;

    // Output register
    logic                 r_out_valid;
    logic [ADDR_BITS-1:0] r_out_addr;
    t_status              r_out_status;

    // Divider hookup
    logic                 div_start;
    logic [DIVD_W-1:0]    div_dividend;
    t_div_stat            div_stat;
    logic [DIVD_W-1:0]    div_quo;
    logic [STRIDE_W-1:0]  div_rem;

    // Layout arithmetic
    logic [ALIGN_W-1:0]   align_sat;
    logic [PAD_W-1:0]     unit_m1;
    logic [OBJ_W-1:0]     obj_min;
    logic [DIVD_W-1:0]    base_next;
    logic [STRIDE_W-1:0]  stride_next;
    logic [PAD_W-1:0]     pad;

    // Request arithmetic
    logic [CHUNK_W-1:0]     scan_hit;
    logic [CHUNK_SEL_W-1:0] scan_sel;
    logic [DIVD_W-1:0]      off_ext;
    logic                   off_bad;
    logic [SLOT_IDX_W-1:0]  free_idx;
    logic [CHUNK_IDX_W-1:0] free_chunk;
    logic [CHUNK_SEL_W-1:0] free_sel;
    logic                   out_free;
    logic                   accept;

    assign accept     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;
    assign free_idx   = div_quo[SLOT_IDX_W-1:0];
    assign free_chunk = free_idx[SLOT_IDX_W-1:CHUNK_SEL_W];
    assign free_sel   = free_idx[CHUNK_SEL_W-1:0];

    // Aligned base, stride and pad from the configuration
    always_comb begin
        align_sat   = (r_align_log2 > ALIGN_W'(MAX_ALIGN)) ? ALIGN_W'(MAX_ALIGN) : r_align_log2;
        unit_m1     = ~({PAD_W{1'b1}} << align_sat);
        obj_min     = (r_object_bytes < OBJ_W'(MIN_OBJ)) ? OBJ_W'(MIN_OBJ) : r_object_bytes;
        base_next   = ({1'b0, r_pool_start} + DIVD_W'(unit_m1)) & ~DIVD_W'(unit_m1);
        stride_next = ({1'b0, obj_min} + STRIDE_W'(unit_m1)) & ~STRIDE_W'(unit_m1);
        pad         = r_base_ext[PAD_W-1:0] - r_pool_start[PAD_W-1:0];
    end

    // Lowest free slot within the current group, limited to the slot count
    always_comb begin
        scan_hit = '0;
        scan_sel = '0;
        for (int j = 0; j < CHUNK_W; j++) begin
            scan_hit[j] = r_map_rd[j]
                && (CNT_W'({r_chunk, CHUNK_SEL_W'(j)}) < r_slot_total);
        end
        for (int j = CHUNK_W - 1; j >= 0; j--) begin
            if (scan_hit[j]) scan_sel = CHUNK_SEL_W'(j);
        end
    end

    // Free range check
    always_comb begin
        off_ext = {1'b0, r_addr} - {1'b0, r_aligned_base};
        off_bad = off_ext[DIVD_W-1] || (off_ext[ADDR_BITS-1:0] >= ADDR_BITS'(r_span));
    end

    // Sequencer: next state and unit controls
    always_comb begin
        n_state      = r_state;
        o_s_tready   = 1'b0;
        div_start    = 1'b0;
        div_dividend = {1'b0, off_ext[ADDR_BITS-1:0]};
        map_raddr    = '0;
        unique case (r_state)
            S_CFG_BASE:      n_state = S_CFG_ROOM;
            S_CFG_ROOM:      n_state = S_CFG_DIV_START;
            S_CFG_DIV_START: begin
                div_start    = 1'b1;
                div_dividend = ({1'b0, r_avail} < r_room) ? {1'b0, r_avail} : r_room;
                n_state      = S_CFG_DIV_WAIT;
            end
            S_CFG_DIV_WAIT:  if (div_stat.done) n_state = S_CFG_SPAN;
            S_CFG_SPAN:      n_state = S_IDLE;
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    n_state = (t_opcode'(i_s_tuser) == OP_FREE) ? S_FREE_CHK : S_ALLOC_SCAN;
                end
            end
            S_ALLOC_SCAN: begin
                // fetch the next group while this one is searched
                map_raddr = r_chunk + 1'b1;
                if (|scan_hit) begin
                    n_state = S_ALLOC_MUL;
                end else if (r_chunk == CHUNK_IDX_W'(NUM_CHUNKS - 1)) begin
                    n_state = S_RESULT;
                end
            end
            S_ALLOC_MUL:     n_state = S_ALLOC_ADD;
            S_ALLOC_ADD:     n_state = S_RESULT;
            S_FREE_CHK: begin
                if (off_bad) begin
                    n_state = S_RESULT;
                end else begin
                    div_start = 1'b1;
                    n_state   = S_FREE_DIV;
                end
            end
            S_FREE_DIV: begin
                map_raddr = free_chunk;
                if (div_stat.done) n_state = S_FREE_UPD;
            end
            S_FREE_UPD:      n_state = S_RESULT;
            S_RESULT:        if (out_free) n_state = S_IDLE;
            default:         n_state = S_IDLE;
        endcase
        // a config write restarts the layout derivation
        if (i_cfg_we) n_state = S_CFG_BASE;
    end

    // State register; reset derives the layout from reset values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_CFG_BASE;
        else          r_state <= n_state;
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_start   <= '0;
            r_pool_bytes   <= '0;
            r_object_bytes <= OBJ_W'(MIN_OBJ);
            r_align_log2   <= ALIGN_W'(3);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_POOL_START:   r_pool_start   <= i_cfg_data[ADDR_BITS-1:0];
                CFG_POOL_BYTES:   r_pool_bytes   <= i_cfg_data[ADDR_BITS-1:0];
                CFG_OBJECT_BYTES: r_object_bytes <= i_cfg_data[OBJ_W-1:0];
                CFG_ALIGN_LOG2:   r_align_log2   <= i_cfg_data[ALIGN_W-1:0];
            endcase
        end
    end

    // Slot count: cleared at reset, then set by the derivation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_total <= '0;
        end else if (r_state == S_CFG_BASE) begin
            r_slot_total <= '0;
        end else if (r_state == S_CFG_DIV_WAIT && div_stat.done) begin
            r_slot_total <= (div_quo > DIVD_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS)
                                                           : div_quo[CNT_W-1:0];
        end
    end

    // Layout datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_CFG_BASE: begin
                r_base_ext <= base_next;
                r_stride   <= stride_next;
            end
            S_CFG_ROOM: begin
                r_avail <= (ADDR_BITS'(pad) < r_pool_bytes) ? r_pool_bytes - ADDR_BITS'(pad)
                                                             : '0;
                r_room  <= {1'b1, {ADDR_BITS{1'b0}}} - r_base_ext;
            end
            S_CFG_DIV_START: r_aligned_base <= r_base_ext[ADDR_BITS-1:0];
            S_CFG_SPAN:      r_span <= SPAN_W'(r_slot_total) * SPAN_W'(r_stride);
            default: ;
        endcase
    end

    // Free map: registered read; cleared one word per cycle during the divider wait
    always_ff @(posedge i_clk) begin
        r_map_rd <= r_free_map[map_raddr];
        unique case (r_state)
            S_CFG_DIV_WAIT: r_free_map[r_chunk] <= '1;
            S_ALLOC_SCAN: begin
                if (|scan_hit) begin
                    r_free_map[r_chunk] <= r_map_rd & ~(CHUNK_W'(1) << scan_sel);
                end
            end
            S_FREE_UPD: begin
                if (div_rem == '0 && !r_map_rd[free_sel]) begin
                    r_free_map[free_chunk] <= r_map_rd | (CHUNK_W'(1) << free_sel);
                end
            end
            default: ;
        endcase
    end

    // Request datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_CFG_DIV_START: r_chunk <= '0;
            S_CFG_DIV_WAIT:  r_chunk <= r_chunk + 1'b1;
            S_IDLE: begin
                if (accept) begin
                    r_addr       <= i_s_tdata[ADDR_BITS-1:0];
                    r_chunk      <= '0;
                    r_res_addr   <= '0;
                    r_res_status <= ST_OK;
                end
            end
            S_ALLOC_SCAN: begin
                if (|scan_hit) begin
                    r_idx <= {r_chunk, scan_sel};
                end else if (r_chunk == CHUNK_IDX_W'(NUM_CHUNKS - 1)) begin
                    r_res_status <= ST_EMPTY;
                end else begin
                    r_chunk <= r_chunk + 1'b1;
                end
            end
            S_ALLOC_MUL: r_prod <= SPAN_W'(r_idx) * SPAN_W'(r_stride);
            S_ALLOC_ADD: r_res_addr <= r_aligned_base + ADDR_BITS'(r_prod);
            S_FREE_CHK: begin
                if (off_bad) r_res_status <= ST_BAD_ADDR;
            end
            S_FREE_UPD: begin
                priority if (div_rem != '0)     r_res_status <= ST_BAD_ADDR;
                else if (r_map_rd[free_sel])    r_res_status <= ST_DOUBLE_FREE;
                else                            r_res_status <= ST_OK;
            end
            default: ;
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_RESULT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_RESULT && out_free) begin
            r_out_addr   <= r_res_addr;
            r_out_status <= r_res_status;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_TDATA_W'({r_out_status, r_out_addr});

    // Shared divider: layout slot count and free slot index
    fspa_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (r_stride),
        .o_stat      (div_stat),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

endmodule

### rtl/fspa_checker.sv
`include "fixed_slot_pool_allocator_unit_assert.svh"

module fspa_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_tvalid,
    input logic                             o_s_tready,
    input logic                             o_m_tvalid,
    input logic                             i_m_tready,
    input logic [fspa_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    input logic                             i_cfg_we
);
    import fspa_pkg::*;

    logic failed_out;
    logic zero_addr;

    assign failed_out = o_m_tvalid && (o_m_tdata[33:32] != ST_OK);
    assign zero_addr  = (o_m_tdata[31:0] == '0);

    // A stalled result stays offered
    `FSPA_ASSERT_NXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid, "stalled result dropped")

    // Any failed request reports a zero address
    `FSPA_ASSERT_IMP(a_fail_zero, failed_out, zero_addr, "nonzero address on failed request")

    // One request at a time: busy right after taking one
    `FSPA_ASSERT_NXT(a_busy_req, i_s_tvalid && o_s_tready, !o_s_tready, "ready after request")

    // A config write starts layout derivation
    `FSPA_ASSERT_NXT(a_cfg_busy, i_cfg_we, !o_s_tready, "ready during layout derivation")

    // Nothing is offered right after reset
    `FSPA_ASSERT_RST(a_rst_idle, !o_m_tvalid && !o_s_tready, "output active after reset")

endmodule

bind fixed_slot_pool_allocator_unit fspa_checker u_fspa_checker (.*);
